// ===== rtl/lrs_pkg.sv =====
// Shared definitions for the loudspeaker resonance and soft clip block.
// Holds default widths, register indexes, reset values and the controller
// command and status types. No dependencies.
package lrs_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int STATE_BITS_DEF  = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int COEF_BITS     = 20;
    localparam int SCALE_BITS    = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_COEF   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_ONE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_TWO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_SCALE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_GAIN     = 3'd4;

    localparam logic signed [COEF_BITS-1:0] INPUT_COEF_RST   = 20'sd4509;
    localparam logic signed [COEF_BITS-1:0] FEEDBACK_ONE_RST = 20'sd103567;
    localparam logic signed [COEF_BITS-1:0] FEEDBACK_TWO_RST = -20'sd41943;
    localparam logic [SCALE_BITS-1:0]       CLIP_SCALE_RST   = 24'd32768;
    localparam logic [SCALE_BITS-1:0]       OUT_GAIN_RST     = 24'd65536;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_X,
        CMD_MUL_Y1,
        CMD_MUL_Y2,
        CMD_ACC,
        CMD_RES,
        CMD_MUL_MS,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_CLIP,
        CMD_MUL_G,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// ===== rtl/loudspeaker_resonance_softclip.sv =====
// Loudspeaker simulator: two-pole resonator, soft clipper, differentiator.
// Top level; joins lrs_ctrl and lrs_datapath. Depends on lrs_pkg.
//
// Input channel: in_valid, in_stall, sample_in. A sample is taken at a
// rising edge with in_valid high and in_stall low. Output channel:
// out_valid, out_stall, sample_out, one result per input sample.
// Settings are written through cfg_we, cfg_index, cfg_data; the user must do so while idle (unenforced).
//
// While one sample occupies the datapath it takes five products on the
// shared multiplier, STATE_BITS - 1 steps of the one-bit-per-cycle
// divider of the soft clipper, and the accumulate, resonator, divider
// setup, clip and output steps. in_stall is high during that time.
// The result sits in an output register, so the next sample is taken
// while it waits; a stalled receiver blocks only the final write step.
// Reset clears the filter history and output valid and loads the default
// settings; the block takes a sample in the first cycle after reset.
module loudspeaker_resonance_softclip #(
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = lrs_pkg::STATE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    input  logic                              cfg_we,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lrs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    lrs_pkg::cmd_t    cmd;
    lrs_pkg::status_t status;

    lrs_ctrl #(
        .STATE_BITS (STATE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (sample_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule

// ===== rtl/lrs_ctrl.sv =====
// Sequencer for the loudspeaker resonance and soft clip block.
// Steps the datapath through resonator, divider and gain stages.
// Depends on lrs_pkg.
module lrs_ctrl #(
    parameter int STATE_BITS = lrs_pkg::STATE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lrs_pkg::status_t status,
    output lrs_pkg::cmd_t    cmd
);

    localparam int QB = STATE_BITS - 1;
    localparam int CW = $clog2(QB);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y1,
        S_MUL_Y2,
        S_ACC,
        S_RES,
        S_MUL_MS,
        S_DIV_INIT,
        S_DIV_STEP,
        S_CLIP,
        S_MUL_G,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            stall_reg, stall_next;

    assign in_stall = stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stall_next = stall_reg;
        cmd        = lrs_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = lrs_pkg::CMD_LOAD;
                    state_next = S_MUL_X;
                    stall_next = 1'b1;
                end
            end
            S_MUL_X:
            begin
                cmd        = lrs_pkg::CMD_MUL_X;
                state_next = S_MUL_Y1;
            end
            S_MUL_Y1:
            begin
                cmd        = lrs_pkg::CMD_MUL_Y1;
                state_next = S_MUL_Y2;
            end
            S_MUL_Y2:
            begin
                cmd        = lrs_pkg::CMD_MUL_Y2;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd        = lrs_pkg::CMD_ACC;
                state_next = S_RES;
            end
            S_RES:
            begin
                cmd        = lrs_pkg::CMD_RES;
                state_next = S_MUL_MS;
            end
            S_MUL_MS:
            begin
                cmd        = lrs_pkg::CMD_MUL_MS;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd        = lrs_pkg::CMD_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd      = lrs_pkg::CMD_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QB - 1))
                begin
                    state_next = S_CLIP;
                end
            end
            S_CLIP:
            begin
                cmd        = lrs_pkg::CMD_CLIP;
                state_next = S_MUL_G;
            end
            S_MUL_G:
            begin
                cmd        = lrs_pkg::CMD_MUL_G;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = lrs_pkg::CMD_OUT;
                    state_next = S_IDLE;
                    stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stall_reg <= stall_next;
        end
    end

endmodule

// ===== rtl/lrs_datapath.sv =====
// Datapath for the loudspeaker resonance and soft clip block: settings,
// shared multiplier, accumulator, serial divider and output register.
// Depends on lrs_pkg.
module lrs_datapath #(
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = lrs_pkg::STATE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrs_pkg::cmd_t                       cmd,
    output lrs_pkg::status_t                    status,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                cfg_we,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lrs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int FRAC = SAMPLE_BITS - 1;
    localparam int SW   = SAMPLE_BITS + 7;
    localparam int AW   = STATE_BITS + 1;
    localparam int BW   = (SW + 1 > 25) ? SW + 1 : 25;
    localparam int PW   = AW + BW;
    localparam int ACW  = PW + 2;
    localparam int QB   = STATE_BITS - 1;
    localparam int DVW  = STATE_BITS + SW;
    localparam int DLW  = ((STATE_BITS > SW) ? STATE_BITS : SW) + 1;
    localparam int MW   = PW - 16;
    localparam int CB   = lrs_pkg::COEF_BITS;
    localparam int GB   = lrs_pkg::SCALE_BITS;

    localparam logic signed [ACW-1:0] YMAX =
        {{(ACW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACW-1:0] YMIN =
        {{(ACW-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
    localparam logic [MW-1:0] NEGL = MW'(1) << (SAMPLE_BITS - 1);
    localparam logic [MW-1:0] POSL = NEGL - MW'(1);

    logic signed [CB-1:0]          a1_reg, b1_reg, b2_reg;
    logic [GB-1:0]                 scale_reg, gain_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [STATE_BITS-1:0]  y1_reg, y2_reg, cprev_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [ACW-1:0]         acc_reg;
    logic [STATE_BITS-1:0]         m_reg;
    logic                          neg_reg;
    logic [DLW-1:0]                d_reg;
    logic [DLW:0]                  rem_reg;
    logic [QB-1:0]                 quo_reg;
    logic                          dzero_reg;
    logic [STATE_BITS-1:0]         dmag_reg;
    logic                          dneg_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic [SW+15:0]                s_wide;
    logic [SW-1:0]                 s_val;
    logic signed [AW-1:0]          mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          prod;
    logic signed [ACW-1:0]         rsum, yshift;
    logic signed [STATE_BITS-1:0]  ysat;
    logic [STATE_BITS-1:0]         yabs;
    logic [DLW:0]                  trial;
    logic                          ge;
    logic [STATE_BITS-1:0]         qv;
    logic signed [STATE_BITS-1:0]  cval;
    logic signed [STATE_BITS:0]    diff;
    logic [PW-1:0]                 rnd;
    logic [MW-1:0]                 mag, mag_sat, mag_neg;
    logic [SAMPLE_BITS-1:0]        out_val;

    assign s_wide = (SW + 16)'(scale_reg) << FRAC;
    assign s_val  = s_wide[SW+15:16];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            lrs_pkg::CMD_MUL_X:
            begin
                mul_a = AW'(x_reg);
                mul_b = BW'(a1_reg);
            end
            lrs_pkg::CMD_MUL_Y1:
            begin
                mul_a = AW'(y1_reg);
                mul_b = BW'(b1_reg);
            end
            lrs_pkg::CMD_MUL_Y2:
            begin
                mul_a = AW'(y2_reg);
                mul_b = BW'(b2_reg);
            end
            lrs_pkg::CMD_MUL_MS:
            begin
                mul_a = $signed({1'b0, m_reg});
                mul_b = $signed(BW'(s_val));
            end
            lrs_pkg::CMD_MUL_G:
            begin
                mul_a = $signed({1'b0, dmag_reg});
                mul_b = $signed(BW'(gain_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    assign rsum   = acc_reg + ACW'(32768);
    assign yshift = rsum >>> 16;
    assign ysat   = (yshift > YMAX) ? STATE_BITS'(YMAX) :
                    (yshift < YMIN) ? STATE_BITS'(YMIN) : STATE_BITS'(yshift);
    assign yabs   = ysat[STATE_BITS-1] ? (~ysat + 1'b1) : ysat;

    assign trial = {rem_reg[DLW-1:0], quo_reg[QB-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    assign qv   = dzero_reg ? '0 : STATE_BITS'(quo_reg);
    assign cval = neg_reg ? -$signed(qv) : $signed(qv);
    assign diff = (STATE_BITS + 1)'(cval) - (STATE_BITS + 1)'(cprev_reg);

    assign rnd     = prod_reg + PW'(32768);
    assign mag     = rnd[PW-1:16];
    assign mag_sat = dneg_reg ? ((mag > NEGL) ? NEGL : mag) : ((mag > POSL) ? POSL : mag);
    assign mag_neg = MW'(0) - mag_sat;
    assign out_val = dneg_reg ? mag_neg[SAMPLE_BITS-1:0] : mag_sat[SAMPLE_BITS-1:0];

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg    <= lrs_pkg::INPUT_COEF_RST;
            b1_reg    <= lrs_pkg::FEEDBACK_ONE_RST;
            b2_reg    <= lrs_pkg::FEEDBACK_TWO_RST;
            scale_reg <= lrs_pkg::CLIP_SCALE_RST;
            gain_reg  <= lrs_pkg::OUT_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrs_pkg::CFG_INPUT_COEF:   a1_reg    <= $signed(cfg_data[CB-1:0]);
                lrs_pkg::CFG_FEEDBACK_ONE: b1_reg    <= $signed(cfg_data[CB-1:0]);
                lrs_pkg::CFG_FEEDBACK_TWO: b2_reg    <= $signed(cfg_data[CB-1:0]);
                lrs_pkg::CFG_CLIP_SCALE:   scale_reg <= cfg_data[GB-1:0];
                lrs_pkg::CFG_OUT_GAIN:     gain_reg  <= cfg_data[GB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg        <= '0;
            y2_reg        <= '0;
            cprev_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == lrs_pkg::CMD_RES)
            begin
                y1_reg <= ysat;
                y2_reg <= y1_reg;
            end
            if (cmd == lrs_pkg::CMD_CLIP)
            begin
                cprev_reg <= cval;
            end
            if (cmd == lrs_pkg::CMD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            lrs_pkg::CMD_LOAD:
            begin
                x_reg <= sample_in;
            end
            lrs_pkg::CMD_MUL_X:
            begin
                prod_reg <= prod;
            end
            lrs_pkg::CMD_MUL_Y1:
            begin
                prod_reg <= prod;
                acc_reg  <= ACW'(prod_reg);
            end
            lrs_pkg::CMD_MUL_Y2:
            begin
                prod_reg <= prod;
                acc_reg  <= acc_reg + ACW'(prod_reg);
            end
            lrs_pkg::CMD_ACC:
            begin
                acc_reg <= acc_reg + ACW'(prod_reg);
            end
            lrs_pkg::CMD_RES:
            begin
                neg_reg <= ysat[STATE_BITS-1];
                m_reg   <= yabs;
                d_reg   <= DLW'(s_val) + DLW'(yabs);
            end
            lrs_pkg::CMD_MUL_MS:
            begin
                prod_reg <= prod;
            end
            lrs_pkg::CMD_DIV_INIT:
            begin
                rem_reg   <= (DLW + 1)'(prod_reg[DVW-1:QB]);
                quo_reg   <= prod_reg[QB-1:0];
                dzero_reg <= (d_reg == '0);
            end
            lrs_pkg::CMD_DIV_STEP:
            begin
                rem_reg <= ge ? (trial - {1'b0, d_reg}) : trial;
                quo_reg <= {quo_reg[QB-2:0], ge};
            end
            lrs_pkg::CMD_CLIP:
            begin
                dneg_reg <= diff[STATE_BITS];
                dmag_reg <= diff[STATE_BITS] ? STATE_BITS'(-diff) : STATE_BITS'(diff);
            end
            lrs_pkg::CMD_MUL_G:
            begin
                prod_reg <= prod;
            end
            lrs_pkg::CMD_OUT:
            begin
                out_reg <= $signed(out_val);
            end
            default:
            begin
            end
        endcase
    end

endmodule
